@@ design/bdq_pkg.sv @@
// Shared types and codes for the bounded deque with listing.
package bdq_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;

   // Operation codes carried by a request
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_SHOW       = 3'd4;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       capture;    // latch request fields
      logic       push;       // write element, update count and, for a front push, the head
      logic       pop;        // drop element, update count and, for a front pop, the head
      logic       rd_first;   // start a walk at the front
      logic       rd_next;    // advance the walk by one slot
      logic       emit_elem;  // load output with walked element
      logic       emit_code;  // load output with a bare status
      status_type code;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            slot_free;
      logic            at_last;
   } sts_type;

endpackage

@@ design/bdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bdq_ctrl.sv @@
// Controller state machine: sequences request decode, updates and listing walks.
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_DECIDE     = 5'b00010,
      S_RESP       = 5'b00100,
      S_LIST_START = 5'b01000,
      S_LIST_DATA  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (sts.op == OP_PUSH_FRONT || sts.op == OP_PUSH_BACK) begin
               if (sts.full) begin
                  code_in = ST_OVERFLOW;
               end else begin
                  cmd.push = 1'b1;
                  code_in  = ST_OK;
               end
               state_in = S_RESP;
            end else if (sts.op == OP_POP_FRONT || sts.op == OP_POP_BACK) begin
               if (sts.empty) begin
                  code_in  = ST_UNDERFLOW;
                  state_in = S_RESP;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = S_LIST_START;
               end
            end else if (sts.op == OP_SHOW) begin
               state_in = S_LIST_START;
            end else begin
               // unused opcode: no result
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (sts.slot_free) begin
               cmd.emit_code = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LIST_START: begin
            if (sts.empty) begin
               code_in  = ST_EMPTY;
               state_in = S_RESP;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = S_LIST_DATA;
            end
         end
         S_LIST_DATA: begin
            if (sts.slot_free) begin
               cmd.emit_elem = 1'b1;
               if (sts.at_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ design/bdq_dp.sv @@
// Datapath: ring store, head and count, listing walk and output register.
module bdq_dp
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W:0]   CAP_WIDE = (CNT_W + 1)'(CAPACITY);

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] pos);
      ring_inc = (pos == LAST_POS) ? '0 : pos + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] pos);
      ring_dec = (pos == '0) ? LAST_POS : pos - 1'b1;
   endfunction

   logic [OP_W-1:0]          op_ff;
   logic [DATA_W-1:0]        value_ff;
   logic [IDX_W-1:0]         head_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [IDX_W-1:0]         walk_ff;
   logic [CNT_W-1:0]         walk_cnt_ff;
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_element_ff;
   logic                     rsp_last_ff;

   logic [CNT_W:0]     back_sum;
   logic [IDX_W-1:0]   back_pos;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic [DATA_W-1:0]  rd_data;
   logic               slot_free;

   // Back slot = head + count, wrapped once
   assign back_sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head_ff} + {1'b0, count_ff};
   always_comb begin
      if (back_sum >= CAP_WIDE) begin
         back_pos = IDX_W'(back_sum - CAP_WIDE);
      end else begin
         back_pos = IDX_W'(back_sum);
      end
   end

   assign wr_addr = (op_ff == OP_PUSH_FRONT) ? ring_dec(head_ff) : back_pos;
   assign rd_addr = cmd.rd_first ? head_ff : ring_inc(walk_ff);

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.rd_first | cmd.rd_next),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
   end

   // Head and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + 1'b1;
         if (op_ff == OP_PUSH_FRONT) begin
            head_ff <= ring_dec(head_ff);
         end
      end else if (cmd.pop) begin
         count_ff <= count_ff - 1'b1;
         if (op_ff == OP_POP_FRONT) begin
            head_ff <= ring_inc(head_ff);
         end
      end
   end

   // Listing walk position and emitted count
   always_ff @(posedge clock) begin
      if (cmd.rd_first || cmd.rd_next) begin
         walk_ff <= rd_addr;
      end
      if (cmd.rd_first) begin
         walk_cnt_ff <= '0;
      end else if (cmd.emit_elem) begin
         walk_cnt_ff <= walk_cnt_ff + 1'b1;
      end
   end

   // Output register
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_code || cmd.emit_elem) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_code) begin
         rsp_status_ff  <= cmd.code;
         rsp_element_ff <= '0;
         rsp_last_ff    <= 1'b1;
      end else if (cmd.emit_elem) begin
         rsp_status_ff  <= ST_OK;
         rsp_element_ff <= rd_data;
         rsp_last_ff    <= sts.at_last;
      end
   end

   // Status to controller
   always_comb begin
      sts.op        = op_ff;
      sts.empty     = (count_ff == '0);
      sts.full      = (count_ff == CAP_CNT);
      sts.slot_free = slot_free;
      sts.at_last   = (({1'b0, walk_cnt_ff} + 1'b1) == {1'b0, count_ff});
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

@@ design/bounded_deque_with_listing.sv @@
// Bounded double-ended queue of signed 32-bit values with front-to-back listing.
// A request carries an operation (push front, push back, pop front, pop back,
// show) and a value. A push answers with one ok or overflow result; a pop on an
// empty queue answers underflow; otherwise a pop or show lists the remaining
// elements front to back, one result per element with last on the final one,
// or a single empty result. Unused opcodes produce nothing. Elements live in a
// RAM of CAPACITY entries addressed as a ring from a head pointer. Requests are
// handled one at a time: the next request is not accepted until the block has
// finished with the last one. The listing rate of one element per cycle, while
// the result channel does not stall, is set by the single RAM read port; a
// stalled result channel holds the listing. No clearing pass is needed after
// reset.
module bounded_deque_with_listing
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last
);

   cmd_type cmd;
   sts_type sts;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bdq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_op      (req_op),
      .req_value   (req_value),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

endmodule

@@ verif/deque_check_pkg.sv @@
// Scoreboard class that predicts and checks the deque's result stream.
package deque_check_pkg;
   import bdq_pkg::*;

   localparam int DEQUE_DEPTH = 16;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] element;
      logic              last;
   } deque_result_type;

   class deque_listing_checker;
      // Shadow copy of the ring and its pointers
      logic [DATA_W-1:0] ring [DEQUE_DEPTH];
      int unsigned       head;
      int unsigned       fill;
      deque_result_type  expected_q[$];

      int errors;
      int n_requests;
      int n_results;
      int n_overflow;
      int n_underflow;
      int n_empty;
      int peak_fill;

      function new();
         head        = 0;
         fill        = 0;
         errors      = 0;
         n_requests  = 0;
         n_results   = 0;
         n_overflow  = 0;
         n_underflow = 0;
         n_empty     = 0;
         peak_fill   = 0;
      endfunction

      function void queue_result(status_type st, logic [DATA_W-1:0] elem, logic last);
         deque_result_type r;
         r.status  = st;
         r.element = elem;
         r.last    = last;
         expected_q.push_back(r);
      endfunction

      // Listing walks front to back; an empty deque gives one empty result
      function void queue_listing();
         int unsigned i;
         if (fill == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
            n_empty++;
         end else begin
            for (i = 0; i < fill; i++)
               queue_result(ST_OK, ring[(head + i) % DEQUE_DEPTH], (i + 1 == fill));
         end
      endfunction

      // Called for every accepted request, in acceptance order
      function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
         n_requests++;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (fill == DEQUE_DEPTH) begin
                  queue_result(ST_OVERFLOW, '0, 1'b1);
                  n_overflow++;
               end else begin
                  if (op == OP_PUSH_FRONT) begin
                     head       = (head + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
                     ring[head] = value;
                  end else begin
                     ring[(head + fill) % DEQUE_DEPTH] = value;
                  end
                  fill++;
                  if (fill > peak_fill)
                     peak_fill = fill;
                  queue_result(ST_OK, '0, 1'b1);
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (fill == 0) begin
                  queue_result(ST_UNDERFLOW, '0, 1'b1);
                  n_underflow++;
               end else begin
                  if (op == OP_POP_FRONT)
                     head = (head + 1) % DEQUE_DEPTH;
                  fill--;
                  queue_listing();
               end
            end
            OP_SHOW: queue_listing();
            default: ;  // unused opcodes answer nothing
         endcase
      endfunction

      // Compare one accepted result against the oldest pending one
      function void check_result(logic [1:0] status, logic [DATA_W-1:0] element, logic last);
         deque_result_type want;
         n_results++;
         if (expected_q.size() == 0) begin
            errors++;
            $error("unexpected result: status %0d element %0h last %0d",
                   status, element, last);
            return;
         end
         want = expected_q.pop_front();
         if (status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, status);
         end
         if (element !== want.element) begin
            errors++;
            $error("element: expected %0h, got %0h", want.element, element);
         end
         if (last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, last);
         end
      endfunction
   endclass

endpackage

@@ verif/tb.sv @@
// Top-level testbench for the bounded deque with listing.
module tb;
   import bdq_pkg::*;
   import deque_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 80;
   localparam int RANDOM_ITEMS   = 400;
   localparam int SEGMENT_LEN    = 20;

   localparam logic [OP_W-1:0]   OP_UNUSED_LO = OP_SHOW + 3'd1;
   localparam logic [OP_W-1:0]   OP_UNUSED_HI = '1;
   localparam logic [DATA_W-1:0] VAL_MIN      = 32'h8000_0000;
   localparam logic [DATA_W-1:0] VAL_MAX      = 32'h7fff_ffff;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;

   bit tx_idle   = 1'b1;
   bit rx_idle   = 1'b1;
   bit long_hold = 1'b0;
   int idle_cycles = 0;

   deque_listing_checker listing_check;

   bounded_deque_with_listing #(.CAPACITY(DEQUE_DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: too long with no request or result moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly random words, with the extremes mixed in
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Offer one request after a random gap; returns at the falling edge
   // after acceptance with valid still high
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
      int gap;
      gap = tx_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      listing_check.note_request(op, value);
      @(negedge clock);
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (listing_check.expected_q.size() != 0)
         @(negedge clock);
   endtask

   // Result side: random stall per result, one long hold on demand
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            hold      = LONG_HOLD;
            long_hold = 1'b0;
         end else begin
            hold = rx_idle ? $urandom_range(0, 4) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         listing_check.check_result(rsp_status, rsp_element, rsp_last);
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      mix_mode_type    mode;
      int              sent;
      int              segment;
      int              r;
      int              push_pct;
      int              pop_pct;
      logic [OP_W-1:0] op;

      listing_check = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = OP_SHOW;
      req_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty cases, extremes, head wrap, every op
      send_request(OP_SHOW, VAL_MAX);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, VAL_MIN);
      send_request(OP_PUSH_FRONT, VAL_MIN);   // head wraps below zero
      send_request(OP_PUSH_BACK, VAL_MAX);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_SHOW, '1);
      send_request(OP_POP_FRONT, VAL_MAX);
      send_request(OP_UNUSED_LO, VAL_MAX);
      send_request(OP_POP_BACK, '1);
      send_request(OP_UNUSED_LO + 3'd1, VAL_MIN);
      send_request(OP_POP_BACK, '0);
      send_request(OP_UNUSED_HI, '1);
      send_request(OP_POP_FRONT, VAL_MIN);    // pop leaves the deque empty
      send_request(OP_SHOW, '0);
      send_request(OP_PUSH_BACK, 32'h0000_0001);
      send_request(OP_SHOW, '0);
      drain_results();

      // Random segments, each with its own op mix and idling pattern
      segment = 0;
      sent    = 0;
      while (sent < RANDOM_ITEMS) begin
         segment++;
         mode    = mix_mode_type'($urandom_range(0, 2));
         tx_idle = ($urandom_range(0, 2) != 0);
         rx_idle = ($urandom_range(0, 2) != 0);
         if (segment == 2) begin
            // results held back while requests keep coming
            mode      = MODE_FILL;
            tx_idle   = 1'b0;
            long_hold = 1'b1;
         end
         if (segment % 4 == 0)
            drain_results();

         case (mode)
            MODE_FILL: begin
               push_pct = 85;
               pop_pct  = 10;
            end
            MODE_DRAIN: begin
               push_pct = 15;
               pop_pct  = 75;
            end
            default: begin
               push_pct = 45;
               pop_pct  = 40;
            end
         endcase

         repeat (SEGMENT_LEN) begin
            if ($urandom_range(0, 99) < 4) begin
               op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else begin
               r = $urandom_range(0, 99);
               if (r < push_pct)
                  op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
               else if (r < push_pct + pop_pct)
                  op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
               else
                  op = OP_SHOW;
            end
            sent++;
            send_request(op, pick_value());
         end
      end

      // Wind down: all results in, then a quiet stretch for strays
      drain_results();
      repeat (3 + DEQUE_DEPTH + 8) @(posedge clock);

      $display("tb: %0d requests, %0d results (%0d overflow, %0d underflow, %0d empty)",
               listing_check.n_requests, listing_check.n_results, listing_check.n_overflow,
               listing_check.n_underflow, listing_check.n_empty);
      $display("tb: %0d segments, peak fill %0d of %0d, one long result hold",
               segment, listing_check.peak_fill, DEQUE_DEPTH);
      if (listing_check.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
